FILE: rtl/core/lfp_pkg.sv
// Shared types and constants for the lidar frame parser with obstacle flags.
// No dependencies; lfp_link and the top module import this package.
package lfp_pkg;

  // Default number of lidar links.
  localparam int NUM_SENSORS_DEF = 4;

  // Fixed frame geometry: two header bytes, payload, checksum as the last byte.
  localparam int FRAME_LEN = 9;
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_DIST_LO = 4'd2;
  localparam logic [IDX_W-1:0] IDX_DIST_HI = 4'd3;
  localparam logic [IDX_W-1:0] IDX_STR_LO = 4'd4;
  localparam logic [IDX_W-1:0] IDX_STR_HI = 4'd5;
  localparam logic [IDX_W-1:0] IDX_CHECKSUM = IDX_W'(FRAME_LEN - 1);

  // Strength value that marks a saturated, unusable reading.
  localparam logic [15:0] STRENGTH_SAT = 16'hFFFF;

  // Register reset values.
  localparam logic [7:0] HEADER_RST = 8'd89;
  localparam logic signed [15:0] RELIABLE_RST = 16'sd1200;
  localparam logic signed [15:0] DANGER_RST = 16'sd30;
  localparam logic [15:0] STRENGTH_MIN_RST = 16'd100;

  // Configuration port geometry.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_HEADER   = 2'd0,
    REG_RELIABLE = 2'd1,
    REG_DANGER   = 2'd2,
    REG_STRENGTH = 2'd3
  } reg_idx_t;

  // What one link parser reports for the byte it just took.
  typedef struct packed {
    logic        done;      // checksum byte of a frame arrived
    logic        good;      // checksum matched
    logic [15:0] distance;
    logic [15:0] strength;
  } link_res_t;

endpackage

FILE: rtl/core/lfp_if.sv
// Valid/ready channel interfaces for the byte input and the frame result.
// Depends on nothing but the port widths fixed by the block.
interface lfp_rx_if;
  logic       valid;
  logic       ready;
  logic [1:0] sensor_index;
  logic [7:0] rx_byte;

  modport source (output valid, output sensor_index, output rx_byte, input ready);
  modport sink (input valid, input sensor_index, input rx_byte, output ready);
endinterface

interface lfp_frame_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_sensor;
  logic signed [15:0] distance;
  logic [15:0]        strength;
  logic [3:0]         obstacle_flags;
  logic [3:0]         danger_flags;

  modport source (
    output valid, output frame_sensor, output distance, output strength,
    output obstacle_flags, output danger_flags, input ready
  );
  modport sink (
    input valid, input frame_sensor, input distance, input strength,
    input obstacle_flags, input danger_flags, output ready
  );
endinterface

FILE: rtl/core/lfp_link.sv
// Parser for one lidar link: header search, byte count, running checksum.
// Depends on lfp_pkg.
module lfp_link (
  input  logic              clk,
  input  logic              rst,
  input  logic              hit,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        header_byte,
  output lfp_pkg::link_res_t res
);
  import lfp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic [IDX_W-1:0] idx_inc;
  logic [7:0]       sum;
  logic [7:0]       sum_next;
  logic [7:0]       dist_lo;
  logic [7:0]       dist_hi;
  logic [7:0]       str_lo;
  logic [7:0]       str_hi;
  logic             is_header;

  assign is_header = (rx_byte == header_byte);
  assign idx_inc = byte_index + IDX_W'(1);

  // Next phase, byte count and checksum for the byte taken in this cycle.
  always_comb begin
    phase_next = phase;
    byte_index_next = byte_index;
    sum_next = sum;
    res.done = 1'b0;
    res.good = 1'b0;
    res.distance = {dist_hi, dist_lo};
    res.strength = {str_hi, str_lo};
    if (hit) begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = is_header ? PH_HEADER : PH_IDLE;
          sum_next = rx_byte;
        end
        PH_HEADER: begin
          if (is_header) begin
            phase_next = PH_BODY;
            byte_index_next = IDX_W'(1);
            sum_next = sum + rx_byte;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_BODY: begin
          byte_index_next = idx_inc;
          if (idx_inc >= IDX_CHECKSUM) begin
            byte_index_next = IDX_CHECKSUM;
            phase_next = PH_IDLE;
            res.done = 1'b1;
            res.good = (sum == rx_byte);
          end else begin
            sum_next = sum + rx_byte;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Parser control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_index <= '0;
    end else begin
      phase <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  // Payload bytes of the frame and the running checksum.
  always_ff @(posedge clk) begin
    sum <= sum_next;
    if (hit && phase == PH_BODY) begin
      if (idx_inc == IDX_DIST_LO) dist_lo <= rx_byte;
      if (idx_inc == IDX_DIST_HI) dist_hi <= rx_byte;
      if (idx_inc == IDX_STR_LO) str_lo <= rx_byte;
      if (idx_inc == IDX_STR_HI) str_hi <= rx_byte;
    end
  end

endmodule

FILE: rtl/core/lidar_frame_parser_obstacle_flags.sv
// Lidar frame parser with per-sensor obstacle and danger flags.
// A result for a frame with a good checksum is registered after its checksum byte passes the input register.
// Throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset (synchronous, active high) idles every link parser, clears the flags
// and loads the register defaults. Depends on lfp_pkg, lfp_if and lfp_link.
module lidar_frame_parser_obstacle_flags #(
  parameter int NUM_SENSORS = lfp_pkg::NUM_SENSORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lfp_rx_if.sink                        rx,
  lfp_frame_if.source                   frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfp_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfp_pkg::*;

  localparam int FW = (NUM_SENSORS > 4) ? NUM_SENSORS : 4;

  // Configuration registers.
  logic [7:0]        header_byte;
  logic signed [15:0] reliable_limit;
  logic signed [15:0] danger_limit;
  logic [15:0]       strength_min;
  reg_idx_t          reg_sel;
  logic              cfg_write;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RST;
      reliable_limit <= RELIABLE_RST;
      danger_limit <= DANGER_RST;
      strength_min <= STRENGTH_MIN_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_HEADER:   header_byte <= pwdata[7:0];
        REG_RELIABLE: reliable_limit <= pwdata[15:0];
        REG_DANGER:   danger_limit <= pwdata[15:0];
        REG_STRENGTH: strength_min <= pwdata[15:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_HEADER:   prdata = {24'd0, header_byte};
      REG_RELIABLE: prdata = {16'd0, reliable_limit};
      REG_DANGER:   prdata = {16'd0, danger_limit};
      REG_STRENGTH: prdata = {16'd0, strength_min};
    endcase
  end

  // Pipeline control: the input stage moves on when the result register is free.
  logic       s1_valid;
  logic [1:0] s1_sensor;
  logic [7:0] s1_byte;
  logic       advance;

  assign advance = !frame.valid || frame.ready;
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_sensor <= rx.sensor_index;
      s1_byte <= rx.rx_byte;
    end
  end

  // One parser per link; a byte tagged with a missing link reaches none.
  link_res_t link_res [NUM_SENSORS];

  for (genvar l = 0; l < NUM_SENSORS; l++) begin : g_link
    logic hit;
    assign hit = s1_valid && advance && ({3'd0, s1_sensor} == 5'(l));
    lfp_link u_link (
      .clk         (clk),
      .rst         (rst),
      .hit         (hit),
      .rx_byte     (s1_byte),
      .header_byte (header_byte),
      .res         (link_res[l])
    );
  end

  // Pick the report of the link that took the byte.
  link_res_t sel;

  always_comb begin
    sel = '0;
    for (int l = 0; l < NUM_SENSORS; l++) begin
      if (link_res[l].done) sel = link_res[l];
    end
  end

  // Obstacle and danger decisions for a frame with a good checksum.
  logic [NUM_SENSORS-1:0] obstacle_bits;
  logic [NUM_SENSORS-1:0] obstacle_bits_next;
  logic [NUM_SENSORS-1:0] danger_bits;
  logic [NUM_SENSORS-1:0] danger_bits_next;
  logic [NUM_SENSORS-1:0] link_mask;
  logic                   frame_good;
  logic                   is_obstacle;
  logic                   is_danger;
  logic [FW-1:0]          obstacle_pad;
  logic [FW-1:0]          danger_pad;

  assign frame_good = sel.done && sel.good;
  assign link_mask = NUM_SENSORS'(1) << s1_sensor;
  assign is_obstacle = (sel.strength > strength_min) && (sel.strength != STRENGTH_SAT)
                       && ($signed(sel.distance) < reliable_limit);
  assign is_danger = is_obstacle && ($signed(sel.distance) < danger_limit);

  always_comb begin
    obstacle_bits_next = obstacle_bits;
    danger_bits_next = danger_bits;
    if (frame_good) begin
      obstacle_bits_next = is_obstacle ? (obstacle_bits | link_mask)
                                       : (obstacle_bits & ~link_mask);
      danger_bits_next = is_danger ? (danger_bits | link_mask)
                                   : (danger_bits & ~link_mask);
    end
  end

  assign obstacle_pad = FW'(obstacle_bits_next);
  assign danger_pad = FW'(danger_bits_next);

  // Flag state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_bits <= '0;
      danger_bits <= '0;
      frame.valid <= 1'b0;
    end else if (advance) begin
      obstacle_bits <= obstacle_bits_next;
      danger_bits <= danger_bits_next;
      frame.valid <= frame_good;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && frame_good) begin
      frame.frame_sensor <= s1_sensor;
      frame.distance <= sel.distance;
      frame.strength <= sel.strength;
      frame.obstacle_flags <= obstacle_pad[3:0];
      frame.danger_flags <= danger_pad[3:0];
    end
  end

endmodule
